// ===== hw/rtl/lis_pkg.sv =====
// Shared types and constants for the lasso ISTA step engine.
package lis_pkg;

  localparam int unsigned MaxRowsDef = 128;
  localparam int unsigned MaxColsDef = 16;

  localparam logic [31:0] StepReset = 32'd21475;
  localparam logic [30:0] ThrReset  = 31'd131;
  localparam logic [7:0]  RowsReset = 8'd100;
  localparam logic [4:0]  ColsReset = 5'd1;

  typedef enum logic [1:0] {
    OpLoadX = 2'd0,
    OpLoadY = 2'd1,
    OpLoadB = 2'd2,
    OpRun   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegStep = 2'd0,
    RegThr  = 2'd1,
    RegRows = 2'd2,
    RegCols = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StResRd,
    StResMul,
    StResAcc,
    StResWr,
    StGrdRd,
    StGrdMul,
    StGrdAcc,
    StStepLo,
    StStepHi,
    StStepSum,
    StOut
  } state_e;

  localparam logic signed [63:0] S64Max = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64Min = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64Min : S64Max;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/lis_cfg.sv =====
// APB configuration registers for the lasso ISTA step engine.
module lis_cfg
  import lis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] step_o,
  output logic [30:0] thr_o,
  output logic [7:0]  rows_o,
  output logic [4:0]  cols_o
);

  logic [31:0] step_q;
  logic [30:0] thr_q;
  logic [7:0]  rows_q;
  logic [4:0]  cols_q;
  logic        wr;
  reg_e        idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      thr_q  <= ThrReset;
      rows_q <= RowsReset;
      cols_q <= ColsReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (idx)
        RegStep: step_q <= pwdata;
        RegThr:  thr_q  <= pwdata[30:0];
        RegRows: rows_q <= pwdata[7:0];
        RegCols: cols_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegStep: prdata = step_q;
      RegThr:  prdata = {1'b0, thr_q};
      RegRows: prdata = {24'd0, rows_q};
      RegCols: prdata = {27'd0, cols_q};
      default: prdata = '0;
    endcase
  end

  assign step_o = step_q;
  assign thr_o  = thr_q;
  assign rows_o = rows_q;
  assign cols_o = cols_q;

endmodule

// ===== hw/rtl/lasso_ista_step.sv =====
// Top level of the lasso ISTA step engine: sequencer, stores and datapath.
//
// Loads (op 0..2) write one matrix, target or coefficient entry. A run (op 3)
// walks the matrix twice: the residual pass reads, multiplies and accumulates
// each matrix entry and writes one residual per row; the gradient pass does
// the same for each entry and then, per column, a step multiply in low and
// high halves, the update and the output. Each memory has one read port. With
// zero rows each coefficient still goes through the step multiply, update and
// output. One item is worked at a time; the input is ready whenever the
// sequencer is idle. Results leave through an output register: the sequencer
// waits on a result that is not yet taken, and every cycle of that wait adds
// to the run. The matrix, targets and residuals sit in RAMs with no reset;
// coefficients reset to zero through per-entry valid bits.
module lasso_ista_step
  import lis_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[1:0], row[8:2], col[12:9], value[44:13], zero fill to 48
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: coef_index[3:0], coef_value[35:4], zero fill to 40
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned XW = RW + CW;
  localparam int unsigned RD = 1 << RW;
  localparam int unsigned CD = 1 << CW;
  localparam int unsigned XD = 1 << XW;

  logic [31:0] step;
  logic [30:0] thr;
  logic [7:0]  rows_cfg;
  logic [4:0]  cols_cfg;

  lis_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .step_o(step), .thr_o(thr), .rows_o(rows_cfg), .cols_o(cols_cfg)
  );

  // input fields
  op_e                in_op;
  logic [6:0]         in_row;
  logic [3:0]         in_col;
  logic signed [31:0] in_val;
  assign in_op  = op_e'(s_axis_tdata[1:0]);
  assign in_row = s_axis_tdata[8:2];
  assign in_col = s_axis_tdata[12:9];
  assign in_val = s_axis_tdata[44:13];

  state_e state_q, state_d;
  logic [12:0] nr_q, nr_d;   // effective rows
  logic [6:0]  nc_q, nc_d;   // effective cols
  logic [12:0] i_q, i_d;
  logic [6:0]  j_q, j_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] part_q, part_d;
  logic signed [31:0] opa_q, opa_d;  // never loaded or read by the datapath
  logic [CD-1:0] bval_q, bval_d;
  logic        ovld_q, ovld_d;
  logic [3:0]  oidx_q, oidx_d;
  logic [31:0] oval_q, oval_d;
  logic        olast_q, olast_d;

  // memories
  logic          x_we, y_we, r_we, b_we;
  logic [XW-1:0] x_wa, x_ra;
  logic [RW-1:0] y_wa, y_ra, r_wa, r_ra;
  logic [CW-1:0] b_wa, b_ra;
  logic [31:0]   x_wd, y_wd, r_wd, b_wd, x_rd, y_rd, r_rd, b_rd;
  logic [CW-1:0] b_ra_q;

  lis_ram #(.Width(32), .Depth(XD)) u_x (.clk_i, .we_i(x_we), .waddr_i(x_wa),
    .wdata_i(x_wd), .raddr_i(x_ra), .rdata_o(x_rd));
  lis_ram #(.Width(32), .Depth(RD)) u_y (.clk_i, .we_i(y_we), .waddr_i(y_wa),
    .wdata_i(y_wd), .raddr_i(y_ra), .rdata_o(y_rd));
  lis_ram #(.Width(32), .Depth(RD)) u_r (.clk_i, .we_i(r_we), .waddr_i(r_wa),
    .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));
  lis_ram #(.Width(32), .Depth(CD)) u_b (.clk_i, .we_i(b_we), .waddr_i(b_wa),
    .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));

  logic signed [31:0] b_eff;
  assign b_eff = bval_q[b_ra_q] ? b_rd : 32'sd0;

  logic [RW-1:0] i_idx;
  logic [CW-1:0] j_idx;
  assign i_idx = i_q[RW-1:0];
  assign j_idx = j_q[CW-1:0];

  logic signed [63:0] diff, shifted, vsum, shrunk;
  logic signed [63:0] lam;
  logic signed [31:0] sx;
  logic signed [32:0] st_s;
  assign lam  = {33'd0, thr};
  assign sx   = x_rd;
  assign st_s = {1'b0, step};

  always_comb begin
    diff    = (acc_q == S64Min) ? S64Max
            : sat_add64({{16{y_rd[31]}}, y_rd, 16'd0}, -acc_q);
    shifted = diff >>> 16;
    vsum    = {{32{b_eff[31]}}, b_eff} + part_q;
    if (vsum > lam) shrunk = vsum - lam;
    else if (vsum < -lam) shrunk = vsum + lam;
    else shrunk = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bval_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bval_q  <= bval_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q <= nr_d; nc_q <= nc_d; i_q <= i_d; j_q <= j_d;
    acc_q <= acc_d; prod_q <= prod_d; part_q <= part_d; opa_q <= opa_d;
    oidx_q <= oidx_d; oval_q <= oval_d; olast_q <= olast_d;
    b_ra_q <= b_ra;
  end

  logic accept;
  assign s_axis_tready = (state_q == StIdle);
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    nr_d = nr_q; nc_d = nc_q; i_d = i_q; j_d = j_q;
    acc_d = acc_q; prod_d = prod_q; part_d = part_q; opa_d = opa_q;
    bval_d = bval_q;
    ovld_d = ovld_q & ~m_axis_tready;
    oidx_d = oidx_q; oval_d = oval_q; olast_d = olast_q;
    x_we = 1'b0; y_we = 1'b0; r_we = 1'b0; b_we = 1'b0;
    x_wa = {RW'(in_row), CW'(in_col)};
    x_wd = in_val; y_wa = RW'(in_row); y_wd = in_val;
    r_wa = i_idx; r_wd = sat32(shifted);
    b_wa = CW'(in_col); b_wd = in_val;
    x_ra = {i_idx, j_idx}; y_ra = i_idx; r_ra = i_idx; b_ra = j_idx;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_op)
            OpLoadX: x_we = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
            OpLoadY: y_we = 32'(in_row) < MAX_ROWS;
            OpLoadB: begin
              if (32'(in_col) < MAX_COLS) begin
                b_we = 1'b1;
                bval_d[b_wa] = 1'b1;
              end
            end
            OpRun: begin
              nr_d = (32'(rows_cfg) > MAX_ROWS) ? 13'(MAX_ROWS) : 13'(rows_cfg);
              nc_d = (32'(cols_cfg) > MAX_COLS) ? 7'(MAX_COLS) : 7'(cols_cfg);
              i_d = '0; j_d = '0; acc_d = '0;
              if (nc_d == '0) state_d = StIdle;
              else if (nr_d == '0) begin
                // zero gradient: the step pass on acc = 0 gives zero and
                // leaves time for the b[j] read
                state_d = StStepLo;
              end else state_d = StResRd;
            end
            default: ;
          endcase
        end
      end
      // residual pass: acc += X[i][j]*b[j]
      StResRd: state_d = StResMul;  // reads X and b issued
      StResMul: begin
        prod_d = 64'(sx) * 64'(b_eff);
        state_d = StResAcc;
      end
      StResAcc: begin
        acc_d = sat_add64(acc_q, prod_q);
        if (j_q + 7'd1 == nc_q) begin
          j_d = '0;
          state_d = StResWr;     // y[i] read issued here
        end else begin
          j_d = j_q + 7'd1;
          state_d = StResRd;
        end
      end
      StResWr: begin
        r_we = 1'b1;
        acc_d = '0;
        if (i_q + 13'd1 == nr_q) begin
          i_d = '0;
          state_d = StGrdRd;
        end else begin
          i_d = i_q + 13'd1;
          state_d = StResRd;
        end
      end
      // gradient pass: g += X[i][j]*r[i]
      StGrdRd: state_d = StGrdMul;
      StGrdMul: begin
        prod_d = 64'(sx) * 64'($signed(r_rd));
        state_d = StGrdAcc;
      end
      StGrdAcc: begin
        acc_d = sat_add64(acc_q, prod_q);
        if (i_q + 13'd1 == nr_q) begin
          i_d = '0;
          state_d = StStepLo;
        end else begin
          i_d = i_q + 13'd1;
          state_d = StGrdRd;
        end
      end
      // t*g: low half unsigned, then high half signed
      StStepLo: begin
        prod_d = $signed({32'd0, 32'(64'(step) * 64'(acc_q[31:0]) >> 32)});
        state_d = StStepHi;
      end
      StStepHi: begin
        part_d = (64'(st_s) * 64'($signed(acc_q[63:32]))) + prod_q;
        part_d = part_d >>> 16;
        state_d = StStepSum;   // b[j] read issued
      end
      StStepSum: begin
        if (!ovld_d) begin
          b_we = 1'b1;
          b_wa = j_idx;
          b_wd = sat32(shrunk);
          bval_d[j_idx] = 1'b1;
          ovld_d = 1'b1;
          oidx_d = 4'(j_q);
          oval_d = sat32(shrunk);
          olast_d = (j_q + 7'd1 == nc_q);
          state_d = StOut;
        end
      end
      StOut: begin
        acc_d = '0;
        i_d = '0;
        if (j_q + 7'd1 == nc_q) begin
          j_d = '0;
          state_d = StIdle;
        end else begin
          j_d = j_q + 7'd1;
          if (nr_q == '0) state_d = StStepLo;
          else state_d = StGrdRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {4'd0, oval_q, oidx_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== sim/tb_lasso_ista_step.sv =====
// Testbench for the lasso ISTA step engine: directed and random requests checked against a predictor.
module tb_lasso_ista_step
  import lis_pkg::*;
();

  // Stimulus widths and model sizes
  localparam int unsigned NRows = 128;
  localparam int unsigned NCols = 16;
  localparam logic signed [63:0] Acc64Max = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] Acc64Min = {1'b1, {63{1'b0}}};

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               lst;
  } coef_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: op[1:0], row[8:2], col[12:9], value[44:13], zero fill to 48
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: coef_index[3:0], coef_value[35:4], zero fill to 40
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lasso_ista_step i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor state: a mirror of the stores and registers
  logic signed [31:0] mat_x [NRows][NCols];
  logic signed [31:0] tgt_y [NRows];
  logic signed [31:0] coef_b [NCols];
  logic signed [31:0] resid [NRows];
  bit                 x_written [NRows][NCols];
  bit                 y_written [NRows];
  logic [31:0]        step_t;
  logic [30:0]        lambda;
  logic [7:0]         rows_reg;
  logic [4:0]         cols_reg;

  coef_t coef_q[$];  // updated coefficients still to arrive
  int    errors;
  int    send_idle;  // percent of cycles the sender idles
  int    recv_idle;  // percent of cycles the receiver stalls
  bit    hold_go;    // toggled to start a long receiver stall
  bit    hold_seen;
  int    hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("lasso_ista_step test failed");
    $finish;
  end

  function automatic logic signed [63:0] acc_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? Acc64Min : Acc64Max;
    return s;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic int eff_rows();
    return (rows_reg > NRows) ? NRows : int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    return (cols_reg > NCols) ? NCols : int'(cols_reg);
  endfunction

  // One ISTA iteration: residual pass, gradient pass, step, soft threshold.
  task automatic predict_iteration();
    int nr;
    int nc;
    logic signed [63:0] acc, diff, a64, b64, g, stp, v, s, lam;
    logic signed [96:0] t97, g97, prod;
    coef_t c;
    nr = eff_rows();
    nc = eff_cols();
    for (int i = 0; i < nr; i++) begin
      acc = '0;
      for (int j = 0; j < nc; j++) begin
        a64 = 64'(mat_x[i][j]);
        b64 = 64'(coef_b[j]);
        acc = acc_add(acc, a64 * b64);
      end
      a64 = 64'(tgt_y[i]);
      if (acc == Acc64Min) diff = Acc64Max;
      else diff = acc_add(a64 <<< 16, -acc);
      resid[i] = clip32(diff >>> 16);
    end
    lam = {33'b0, lambda};
    t97 = {65'b0, step_t};
    for (int j = 0; j < nc; j++) begin
      g = '0;
      for (int i = 0; i < nr; i++) begin
        a64 = 64'(mat_x[i][j]);
        b64 = 64'(resid[i]);
        g = acc_add(g, a64 * b64);
      end
      g97 = 97'(g);
      prod = t97 * g97;
      stp = 64'(prod >>> 48);
      b64 = 64'(coef_b[j]);
      v = b64 + stp;
      if (v > lam) s = v - lam;
      else if (v < -lam) s = v + lam;
      else s = '0;
      coef_b[j] = clip32(s);
      c.idx = j[3:0];
      c.val = coef_b[j];
      c.lst = (j + 1 == nc);
      coef_q = {coef_q, c};
    end
  endtask

  // Result checker: compares each taken coefficient with the oldest prediction.
  always @(posedge clk_i) begin
    coef_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d val=%0d last=%0b", $time,
                 m_axis_tdata[3:0], $signed(m_axis_tdata[35:4]), m_axis_tlast);
        errors++;
      end else begin
        e = coef_q.pop_front();
        if (m_axis_tdata[3:0] !== e.idx) begin
          $display("%0t: coef_index expected %0d actual %0d", $time, e.idx,
                   m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[35:4] !== e.val) begin
          $display("%0t: coef_value expected %0d actual %0d", $time, e.val,
                   $signed(m_axis_tdata[35:4]));
          errors++;
        end
        if (m_axis_tlast !== e.lst) begin
          $display("%0t: last expected %0b actual %0b", $time, e.lst, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt  <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sends one request; valid stays high on return so back-to-back requests need no gap.
  task automatic send_req(op_e op, logic [6:0] row, logic [3:0] col, logic [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, val, col, row, op};
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OpLoadX: begin
        mat_x[row][col] = val;
        x_written[row][col] = 1'b1;
      end
      OpLoadY: begin
        tgt_y[row] = val;
        y_written[row] = 1'b1;
      end
      OpLoadB: coef_b[col] = val;
      default: predict_iteration();
    endcase
  endtask

  // Stop offering, wait for all coefficients, then let the engine settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (coef_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegStep: step_t   = val;
      RegThr:  lambda   = val[30:0];
      RegRows: rows_reg = val[7:0];
      default: cols_reg = val[4:0];
    endcase
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65535)) - 32768) <<< 4;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  // Writes every matrix and target entry the next run will read but nobody loaded yet.
  task automatic fill_used();
    for (int i = 0; i < eff_rows(); i++) begin
      for (int j = 0; j < eff_cols(); j++)
        if (!x_written[i][j]) send_req(OpLoadX, i[6:0], j[3:0], rand_val());
      if (!y_written[i]) send_req(OpLoadY, i[6:0], 4'($urandom), rand_val());
    end
  endtask

  task automatic run_iter();
    fill_used();
    send_req(OpRun, 7'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic set_regs(logic [31:0] st, logic [31:0] th, logic [31:0] nr, logic [31:0] nc);
    apb_write(RegStep, st);
    apb_write(RegThr, th);
    apb_write(RegRows, nr);
    apb_write(RegCols, nc);
  endtask

  // Reset values of step, threshold and column count, over three rows.
  task automatic test_reset_regs();
    apb_write(RegRows, 32'd3);
    run_iter();
    run_iter();
    drain();
  endtask

  // Extreme values and extreme register settings.
  task automatic test_extremes();
    set_regs(32'hffffffff, 32'h0, 32'd2, 32'd3);
    send_req(OpLoadX, 7'd0, 4'd0, 32'h80000000);
    send_req(OpLoadX, 7'd0, 4'd1, 32'h7fffffff);
    send_req(OpLoadX, 7'd1, 4'd2, 32'h80000000);
    send_req(OpLoadY, 7'd0, 4'd15, 32'h7fffffff);
    send_req(OpLoadY, 7'd1, 4'd0, 32'h80000000);
    send_req(OpLoadB, 7'd127, 4'd0, 32'h80000000);
    send_req(OpLoadB, 7'd0, 4'd1, 32'h7fffffff);
    send_req(OpLoadB, 7'd0, 4'd2, 32'h80000000);
    send_req(OpLoadB, 7'd0, 4'd15, 32'h12345678);  // unused column keeps its value
    send_req(OpLoadX, 7'd127, 4'd15, 32'hffffffff);
    run_iter();
    run_iter();
    drain();
    set_regs(32'h0, 32'h7fffffff, 32'd1, 32'd2);
    run_iter();
    drain();
    // zero rows: only the threshold acts on the current coefficients
    set_regs(32'h80000000, 32'd70000, 32'd0, 32'd16);
    for (int j = 0; j < 4; j++) send_req(OpLoadB, 7'd0, 4'($urandom), rand_val());
    run_iter();
    drain();
    // zero columns: no result
    apb_write(RegCols, 32'd0);
    run_iter();
    drain();
    // oversized column count acts as the maximum
    set_regs(32'd21475, 32'd131, 32'd3, 32'd31);
    run_iter();
    drain();
  endtask

  // Random requests over several register settings and idle patterns.
  task automatic test_random(int n_items);
    int pick;
    for (int k = 0; k < n_items; k++) begin
      if (k % 16 == 0) begin
        drain();
        set_regs(($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 26),
                 $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 14),
                 $urandom_range(1, 3), $urandom_range(1, 16));
      end
      pick = $urandom_range(99);
      if (pick < 40) send_req(OpLoadX, 7'($urandom), 4'($urandom), rand_val());
      else if (pick < 55) send_req(OpLoadY, 7'($urandom), 4'($urandom), rand_val());
      else if (pick < 70) send_req(OpLoadB, 7'($urandom), 4'($urandom), rand_val());
      else if (pick < 80) begin
        // loads inside the region in use, so runs see fresh data
        send_req(OpLoadX, 7'($urandom_range(eff_rows() - 1)),
                 4'($urandom_range(eff_cols() - 1)), rand_val());
      end else run_iter();
    end
    drain();
  endtask

  // Long receiver hold-off while runs keep arriving: the engine must stall its input.
  task automatic test_backpressure();
    set_regs(32'd50000000, 32'd200, 32'd3, 32'd16);
    hold_go = ~hold_go;
    for (int k = 0; k < 6; k++) run_iter();
    drain();
  endtask

  initial begin
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b0;
    hold_seen = 1'b0;
    hold_cnt = 0;
    step_t = StepReset;
    lambda = ThrReset;
    rows_reg = RowsReset;
    cols_reg = ColsReset;
    for (int j = 0; j < NCols; j++) coef_b[j] = '0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 17;
    recv_idle = 86;
    test_reset_regs();
    test_extremes();
    test_random(21);
    send_idle = 86;
    recv_idle = 17;
    test_random(21);
    test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    test_random(21);

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("lasso_ista_step test passed");
    end else begin
      $display("lasso_ista_step test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lis_pkg.sv
hw/rtl/lis_ram.sv
hw/rtl/lis_cfg.sv
hw/rtl/lasso_ista_step.sv
sim/tb_lasso_ista_step.sv
